[rtl/core/throughput_order_statistics_defines.svh]
// ----------------------------------------------------------------------------
// Throughput order statistics: assertion macros
// Shared property wrappers, clocked on i_clk and disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef THROUGHPUT_ORDER_STATISTICS_DEFINES_SVH
`define THROUGHPUT_ORDER_STATISTICS_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TOS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TOS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/tos_pkg.sv]
// ----------------------------------------------------------------------------
// Throughput order statistics package
// Sizes, arithmetic constants and the types passed between the blocks.
// ----------------------------------------------------------------------------
package tos_pkg;

    localparam int MAX_SAMPLES = 32;
    localparam int SMP_W       = 24;
    localparam int VAL_W       = 23;
    localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
    localparam int ADDR_W      = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;

    // Division by five through a reciprocal; exact for dividends below 2^14.
    localparam int              FIFTH_SHIFT = 14;
    localparam logic [11:0]     FIFTH_RECIP = 12'd3277;
    localparam int              RANK_W      = CNT_W + 1 + 12;

    // Division by ten through a reciprocal; exact for any 32-bit dividend.
    localparam int              TENTH_SHIFT = 35;
    localparam logic [31:0]     TENTH_RECIP = 32'hCCCC_CCCD;
    localparam int              NINE_W      = VAL_W + 4;
    localparam int              PROD_W      = NINE_W + 32;

    typedef struct packed {
        logic             nonempty;
        logic [CNT_W-1:0] count;
        logic [VAL_W-1:0] median;
        logic [VAL_W-1:0] p20;
    } t_stat;

    typedef struct packed {
        logic             nonempty;
        logic [CNT_W-1:0] count;
        logic [VAL_W-1:0] median;
        logic [VAL_W-1:0] p20;
        logic [VAL_W-1:0] optimal;
        logic [VAL_W-1:0] ceiling;
    } t_summary;

    // Nearest-rank index of the 20th percentile: ceil(m / 5) - 1, floored at 0.
    function automatic logic [ADDR_W-1:0] p20_index(input logic [CNT_W-1:0] m);
        logic [CNT_W:0]    bumped;
        logic [RANK_W-1:0] prod;
        logic [RANK_W-1:0] rank;
        bumped = {1'b0, m} + (CNT_W + 1)'(4);
        prod   = RANK_W'(bumped) * RANK_W'(FIFTH_RECIP);
        rank   = prod >> FIFTH_SHIFT;
        if (rank != '0) begin
            rank = rank - RANK_W'(1);
        end
        return rank[ADDR_W-1:0];
    endfunction

endpackage

[rtl/core/tos_sorter.sv]
// ----------------------------------------------------------------------------
// Sorted sample store
// Insertion sort into a one-port-read, one-port-write memory, and the
// readout of the middle pair and the 20th-percentile entry at batch end.
// ----------------------------------------------------------------------------
module tos_sorter (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [tos_pkg::SMP_W-1:0]   i_sample,
    input  logic                        i_last,
    output logic                        o_item_done,
    output logic                        o_stat_valid,
    output tos_pkg::t_stat              o_stat
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_PUT,
        S_END,
        S_HI,
        S_LO,
        S_RANK
    } t_state;

    logic [tos_pkg::VAL_W-1:0] r_mem [tos_pkg::MAX_SAMPLES];
    logic [tos_pkg::VAL_W-1:0] r_rdata;

    t_state                     r_state, n_state;
    logic [tos_pkg::CNT_W-1:0]  r_count, n_count;
    logic [tos_pkg::ADDR_W-1:0] r_pos, n_pos;
    logic [tos_pkg::VAL_W-1:0]  r_value, n_value;
    logic                       r_last, n_last;
    logic [tos_pkg::VAL_W-1:0]  r_hi, n_hi;
    logic [tos_pkg::VAL_W-1:0]  r_lo, n_lo;
    logic                       r_item_done, n_item_done;
    logic                       r_stat_valid, n_stat_valid;
    tos_pkg::t_stat             r_stat, n_stat;

    logic                       rd_en;
    logic [tos_pkg::ADDR_W-1:0] rd_addr;
    logic                       wr_en;
    logic [tos_pkg::ADDR_W-1:0] wr_addr;
    logic [tos_pkg::VAL_W-1:0]  wr_data;
    logic                       keep;
    logic [tos_pkg::ADDR_W-1:0] half;
    logic [tos_pkg::VAL_W:0]    mid_sum;

    // During a shift the write goes to pos and the read to pos - 2, so the
    // two ports never meet on one entry and no forwarding is needed.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    assign keep    = !i_sample[tos_pkg::SMP_W-1] && (r_count < tos_pkg::CNT_W'(tos_pkg::MAX_SAMPLES));
    assign half    = tos_pkg::ADDR_W'(r_count >> 1);
    assign mid_sum = {1'b0, r_hi} + {1'b0, r_lo} + (tos_pkg::VAL_W + 1)'(1);

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_pos        = r_pos;
        n_value      = r_value;
        n_last       = r_last;
        n_hi         = r_hi;
        n_lo         = r_lo;
        n_item_done  = 1'b0;
        n_stat_valid = 1'b0;
        n_stat       = r_stat;
        rd_en        = 1'b0;
        rd_addr      = r_pos - tos_pkg::ADDR_W'(1);
        wr_en        = 1'b0;
        wr_addr      = r_pos;
        wr_data      = r_value;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_value = i_sample[tos_pkg::VAL_W-1:0];
                    n_last  = i_last;
                    n_pos   = r_count[tos_pkg::ADDR_W-1:0];
                    if (!keep) begin
                        n_state = S_END;
                    end else if (r_count == '0) begin
                        n_state = S_PUT;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = tos_pkg::ADDR_W'(r_count - tos_pkg::CNT_W'(1));
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                wr_en = 1'b1;
                if (r_rdata > r_value) begin
                    // Move the larger entry up one place and look further down.
                    wr_data = r_rdata;
                    n_pos   = r_pos - tos_pkg::ADDR_W'(1);
                    if (r_pos == tos_pkg::ADDR_W'(1)) begin
                        n_state = S_PUT;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = r_pos - tos_pkg::ADDR_W'(2);
                    end
                end else begin
                    n_count = r_count + tos_pkg::CNT_W'(1);
                    n_state = S_END;
                end
            end
            S_PUT: begin
                wr_en   = 1'b1;
                n_count = r_count + tos_pkg::CNT_W'(1);
                n_state = S_END;
            end
            S_END: begin
                if (!r_last) begin
                    n_item_done = 1'b1;
                    n_state     = S_IDLE;
                end else if (r_count == '0) begin
                    n_stat       = '0;
                    n_stat_valid = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = half;
                    n_state = S_HI;
                end
            end
            S_HI: begin
                n_hi    = r_rdata;
                rd_en   = 1'b1;
                rd_addr = r_count[0] ? half : half - tos_pkg::ADDR_W'(1);
                n_state = S_LO;
            end
            S_LO: begin
                n_lo    = r_rdata;
                rd_en   = 1'b1;
                rd_addr = tos_pkg::p20_index(r_count);
                n_state = S_RANK;
            end
            S_RANK: begin
                // For an odd count both halves are the same entry.
                n_stat.nonempty = 1'b1;
                n_stat.count    = r_count;
                n_stat.median   = mid_sum[tos_pkg::VAL_W:1];
                n_stat.p20      = r_rdata;
                n_stat_valid    = 1'b1;
                n_count         = '0;
                n_state         = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_item_done  <= 1'b0;
            r_stat_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_item_done  <= n_item_done;
            r_stat_valid <= n_stat_valid;
        end
        r_pos   <= n_pos;
        r_value <= n_value;
        r_last  <= n_last;
        r_hi    <= n_hi;
        r_lo    <= n_lo;
        r_stat  <= n_stat;
    end

    assign o_item_done  = r_item_done;
    assign o_stat_valid = r_stat_valid;
    assign o_stat       = r_stat;

endmodule

[rtl/core/tos_stats.sv]
// ----------------------------------------------------------------------------
// Derived throughput values
// Scales the 20th percentile by 3/4 and the median by 9/10, both rounded
// half up, and holds the finished summary until the output stage takes it.
// ----------------------------------------------------------------------------
module tos_stats (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_stat_valid,
    input  tos_pkg::t_stat      i_stat,
    input  logic                i_taken,
    output logic                o_res_valid,
    output tos_pkg::t_summary   o_res
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_HOLD
    } t_state;

    t_state                      r_state;
    tos_pkg::t_stat              r_stat;
    logic [tos_pkg::NINE_W-1:0]  r_nine;
    logic [tos_pkg::VAL_W-1:0]   r_optimal;
    logic [tos_pkg::PROD_W-1:0]  r_prod;

    logic [tos_pkg::NINE_W-1:0]  nine;
    logic [tos_pkg::VAL_W+1:0]   three;

    // (90 m + 50) / 100 reduces to (9 m + 5) / 10, and (75 p + 50) / 100
    // to (3 p + 2) / 4.
    assign nine  = tos_pkg::NINE_W'(i_stat.median) * tos_pkg::NINE_W'(9)
                 + tos_pkg::NINE_W'(5);
    assign three = (tos_pkg::VAL_W + 2)'(i_stat.p20) * (tos_pkg::VAL_W + 2)'(3)
                 + (tos_pkg::VAL_W + 2)'(2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_stat_valid) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_state <= S_HOLD;
                end
                S_HOLD: begin
                    if (i_taken) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
        if (r_state == S_IDLE && i_stat_valid) begin
            r_stat    <= i_stat;
            r_nine    <= nine;
            r_optimal <= three[tos_pkg::VAL_W+1:2];
        end
        if (r_state == S_MUL) begin
            r_prod <= tos_pkg::PROD_W'(r_nine) * tos_pkg::PROD_W'(tos_pkg::TENTH_RECIP);
        end
    end

    assign o_res_valid    = (r_state == S_HOLD);
    assign o_res.nonempty = r_stat.nonempty;
    assign o_res.count    = r_stat.count;
    assign o_res.median   = r_stat.median;
    assign o_res.p20      = r_stat.p20;
    assign o_res.optimal  = r_optimal;
    assign o_res.ceiling  = r_prod[tos_pkg::TENTH_SHIFT +: tos_pkg::VAL_W];

endmodule

[rtl/core/throughput_order_statistics.sv]
// ----------------------------------------------------------------------------
// Throughput order statistics
// Median, 20th percentile and derived rates over a batch of kbps samples.
// ----------------------------------------------------------------------------
// One beat in carries one signed kbps sample and a last flag; negative samples
// are dropped, and up to tos_pkg::MAX_SAMPLES samples per batch are kept in
// ascending order in a single memory, later ones being ignored. The beat that
// carries the last flag closes the batch and produces one summary beat: kept
// count, median (mean of the middle pair rounded up for an even count), the
// 20th percentile by nearest rank, three quarters of that percentile and nine
// tenths of the median, both rounded half up. An empty batch gives a summary
// with summary_valid low and every field zero. Items are handled one at a
// time: a dropped or ignored sample skips the store, and an insertion behind
// k larger stored samples shifts each of them up one place, walking the store
// one entry per cycle through its single read port. A closing beat then reads
// the middle pair and the percentile entry and scales the results before the
// summary reaches the output register, and waits while that register still
// holds a summary that has not been taken. That register frees the input
// side, so a new batch may start while a summary waits to be taken.
// ----------------------------------------------------------------------------
module throughput_order_statistics (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic signed [tos_pkg::SMP_W-1:0]   i_sample_kbps,
    input  logic                               i_last_sample,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic                               o_summary_valid,
    output logic        [tos_pkg::CNT_W-1:0]   o_kept_count,
    output logic        [tos_pkg::VAL_W-1:0]   o_median_kbps,
    output logic        [tos_pkg::VAL_W-1:0]   o_low_percentile_kbps,
    output logic        [tos_pkg::VAL_W-1:0]   o_optimal_kbps,
    output logic        [tos_pkg::VAL_W-1:0]   o_ceiling_kbps
);

    `include "throughput_order_statistics_defines.svh"

    logic               r_busy;
    logic               r_out_valid;
    tos_pkg::t_summary  r_out;

    logic               accept;
    logic               item_done;
    logic               stat_valid;
    tos_pkg::t_stat     stat;
    logic               res_valid;
    tos_pkg::t_summary  res;
    logic               load;
    logic               fields_zero;
    logic               stats_ordered;
    logic               count_ok;

    // The block takes a new beat only once the previous one has been fully
    // absorbed: either its sample was stored or dropped, or its summary was
    // moved into the output register.
    assign accept = i_valid && !r_busy;
    assign load   = res_valid && (!r_out_valid || i_ready);

    tos_sorter u_sorter (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (accept),
        .i_sample     (i_sample_kbps),
        .i_last       (i_last_sample),
        .o_item_done  (item_done),
        .o_stat_valid (stat_valid),
        .o_stat       (stat)
    );

    tos_stats u_stats (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_stat_valid (stat_valid),
        .i_stat       (stat),
        .i_taken      (load),
        .o_res_valid  (res_valid),
        .o_res        (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_busy <= 1'b1;
            end else if (item_done || load) begin
                r_busy <= 1'b0;
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (load) begin
            r_out <= res;
        end
    end

    assign o_ready               = !r_busy;
    assign o_valid               = r_out_valid;
    assign o_summary_valid       = r_out.nonempty;
    assign o_kept_count          = r_out.count;
    assign o_median_kbps         = r_out.median;
    assign o_low_percentile_kbps = r_out.p20;
    assign o_optimal_kbps        = r_out.optimal;
    assign o_ceiling_kbps        = r_out.ceiling;

    assign fields_zero   = o_kept_count == '0 && o_median_kbps == '0
                        && o_low_percentile_kbps == '0 && o_optimal_kbps == '0
                        && o_ceiling_kbps == '0;
    assign stats_ordered = o_optimal_kbps <= o_low_percentile_kbps
                        && o_ceiling_kbps <= o_median_kbps
                        && o_low_percentile_kbps <= o_median_kbps;
    assign count_ok      = o_kept_count <= tos_pkg::CNT_W'(tos_pkg::MAX_SAMPLES)
                        && (o_summary_valid == (o_kept_count != '0));

    // An empty batch must leave every numeric field at zero.
    `TOS_ASSERT_NOW(a_empty_zero, o_valid && !o_summary_valid, fields_zero, "empty summary carries nonzero fields")

    // Ordering of the statistics: scaled values never exceed their source,
    // and the 20th percentile never exceeds the median.
    `TOS_ASSERT_NOW(a_order, o_valid && o_summary_valid, stats_ordered, "summary statistics out of order")

    // The kept count stays within the store and agrees with summary_valid.
    `TOS_ASSERT_NOW(a_count, o_valid, count_ok, "kept count inconsistent")

    // An accepted beat keeps the block occupied in the following cycle.
    `TOS_ASSERT_NEXT(a_busy_after_accept, i_valid && o_ready, !o_ready, "ready stayed high after a beat was taken")

endmodule
